/* src/chgs_pkg.sv */
package chgs_pkg;

	// Default build sizes
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 16;

	// Smallest set that has a hull
	localparam int MIN_HULL = 3;

	// Width of the coordinate fields on the ports
	localparam int FIELD_W = 16;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic store_we;
		logic sort_we;
		logic sort_wsel;   // 1: write the compared word, 0: write the word being inserted
		logic stack_we;
		logic piv_upd;
		logic piv_first;
		logic cur_ld;
		logic sref_ld;
		logic p_ld;
		logic turn_scan;   // 1: turn of the scan stack, 0: angle compare around the pivot
		logic push;
		logic pop;
		logic sec_ld;
		logic out_ld;
		logic out_zero;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic turn_pos;
		logic ahead;
	} dp_stat_t;

endpackage

/* src/chgs_ram.sv */
module chgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/chgs_datapath.sv */
module chgs_datapath #(
	parameter int MAX_POINTS = chgs_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = chgs_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  chgs_pkg::dp_cmd_t                     cmd,
	output chgs_pkg::dp_stat_t                    stat,
	input  logic [$clog2(MAX_POINTS)-1:0]         store_waddr,
	input  logic [$clog2(MAX_POINTS)-1:0]         store_raddr,
	input  logic [$clog2(MAX_POINTS)-1:0]         sort_waddr,
	input  logic [$clog2(MAX_POINTS)-1:0]         sort_raddr,
	input  logic [$clog2(MAX_POINTS)-1:0]         stack_waddr,
	input  logic [$clog2(MAX_POINTS)-1:0]         stack_raddr,
	input  logic signed [chgs_pkg::FIELD_W-1:0]   point_x,
	input  logic signed [chgs_pkg::FIELD_W-1:0]   point_y,
	output logic signed [chgs_pkg::FIELD_W-1:0]   vertex_x,
	output logic signed [chgs_pkg::FIELD_W-1:0]   vertex_y
);

	import chgs_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int PW  = 2 * COORD_BITS;
	localparam int EW  = COORD_BITS + FIELD_W;
	localparam int PRW = 2 * COORD_BITS + 2;

	logic signed [EW-1:0] in_ext_x, in_ext_y, out_ext_x, out_ext_y;
	logic [PW-1:0] store_wdata, store_rdata, sort_wdata, sort_rdata, stack_wdata, stack_rdata;
	logic signed [CW-1:0] st_x, st_y, so_x, so_y, sk_x, sk_y;
	logic signed [CW-1:0] piv_x_q, piv_y_q, cur_x_q, cur_y_q, sref_x_q, sref_y_q;
	logic signed [CW-1:0] p_x_q, p_y_q, top_x_q, top_y_q, sec_x_q, sec_y_q;
	logic signed [CW-1:0] o_x, o_y, a_x, a_y, b_x, b_y;
	logic signed [CW:0] ax, ay, bx, by;
	logic signed [PRW-1:0] prod_p_s1, prod_q_s1;
	logic piv_take, same_sp, same_cp, lex_lt, turn_eq;

	// Take the low coordinate bits, sign-extended
	assign in_ext_x    = EW'(point_x);
	assign in_ext_y    = EW'(point_y);
	assign store_wdata = {in_ext_y[CW-1:0], in_ext_x[CW-1:0]};
	assign sort_wdata  = cmd.sort_wsel ? {sref_y_q, sref_x_q} : {cur_y_q, cur_x_q};
	assign stack_wdata = {p_y_q, p_x_q};

	chgs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
		.clk(clk), .we(cmd.store_we), .waddr(store_waddr), .wdata(store_wdata),
		.raddr(store_raddr), .rdata(store_rdata)
	);

	chgs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_sorted (
		.clk(clk), .we(cmd.sort_we), .waddr(sort_waddr), .wdata(sort_wdata),
		.raddr(sort_raddr), .rdata(sort_rdata)
	);

	chgs_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_stack (
		.clk(clk), .we(cmd.stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
		.raddr(stack_raddr), .rdata(stack_rdata)
	);

	assign st_x = store_rdata[CW-1:0];
	assign st_y = store_rdata[PW-1:CW];
	assign so_x = sort_rdata[CW-1:0];
	assign so_y = sort_rdata[PW-1:CW];
	assign sk_x = stack_rdata[CW-1:0];
	assign sk_y = stack_rdata[PW-1:CW];

	// Pivot is the lowest y, then the lowest x
	assign piv_take = cmd.piv_first || (st_y < piv_y_q) || (st_y == piv_y_q && st_x < piv_x_q);

	// Select the turn operands
	assign o_x = cmd.turn_scan ? sec_x_q : piv_x_q;
	assign o_y = cmd.turn_scan ? sec_y_q : piv_y_q;
	assign a_x = cmd.turn_scan ? top_x_q : cur_x_q;
	assign a_y = cmd.turn_scan ? top_y_q : cur_y_q;
	assign b_x = cmd.turn_scan ? p_x_q   : sref_x_q;
	assign b_y = cmd.turn_scan ? p_y_q   : sref_y_q;

	assign ax = {a_x[CW-1], a_x} - {o_x[CW-1], o_x};
	assign ay = {a_y[CW-1], a_y} - {o_y[CW-1], o_y};
	assign bx = {b_x[CW-1], b_x} - {o_x[CW-1], o_x};
	assign by = {b_y[CW-1], b_y} - {o_y[CW-1], o_y};

	// Hold the coordinate registers and the cross-product terms
	always_ff @(posedge clk) begin
		prod_p_s1 <= PRW'(ax) * PRW'(by);
		prod_q_s1 <= PRW'(ay) * PRW'(bx);
		if (cmd.piv_upd && piv_take) begin
			piv_x_q <= st_x;
			piv_y_q <= st_y;
		end
		if (cmd.cur_ld) begin
			cur_x_q <= st_x;
			cur_y_q <= st_y;
		end
		if (cmd.sref_ld) begin
			sref_x_q <= so_x;
			sref_y_q <= so_y;
		end
		if (cmd.p_ld) begin
			p_x_q <= so_x;
			p_y_q <= so_y;
		end
		if (cmd.push) begin
			sec_x_q <= top_x_q;
			sec_y_q <= top_y_q;
			top_x_q <= p_x_q;
			top_y_q <= p_y_q;
		end else if (cmd.pop) begin
			top_x_q <= sec_x_q;
			top_y_q <= sec_y_q;
		end else if (cmd.sec_ld) begin
			sec_x_q <= sk_x;
			sec_y_q <= sk_y;
		end
		if (cmd.out_ld) begin
			vertex_x <= out_ext_x[FIELD_W-1:0];
			vertex_y <= out_ext_y[FIELD_W-1:0];
		end else if (cmd.out_zero) begin
			vertex_x <= '0;
			vertex_y <= '0;
		end
	end

	assign out_ext_x = EW'(sk_x);
	assign out_ext_y = EW'(sk_y);

	// Angle order around the pivot; a collinear pair is ordered by distance along the ray
	assign same_sp = (sref_x_q == piv_x_q) && (sref_y_q == piv_y_q);
	assign same_cp = (cur_x_q == piv_x_q) && (cur_y_q == piv_y_q);
	assign lex_lt  = (cur_y_q < sref_y_q) || (cur_y_q == sref_y_q && cur_x_q < sref_x_q);
	assign turn_eq = (prod_p_s1 == prod_q_s1);

	assign stat.turn_pos = prod_p_s1 > prod_q_s1;
	assign stat.ahead    = !same_sp && (same_cp || (turn_eq ? lex_lt : stat.turn_pos));

endmodule

/* src/chgs_ctrl.sv */
module chgs_ctrl #(
	parameter int MAX_POINTS = chgs_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          last_vertex,
	output logic                          hull_empty,
	output logic                          overflow,
	output chgs_pkg::dp_cmd_t             cmd,
	input  chgs_pkg::dp_stat_t            stat,
	output logic [$clog2(MAX_POINTS)-1:0] store_waddr,
	output logic [$clog2(MAX_POINTS)-1:0] store_raddr,
	output logic [$clog2(MAX_POINTS)-1:0] sort_waddr,
	output logic [$clog2(MAX_POINTS)-1:0] sort_raddr,
	output logic [$clog2(MAX_POINTS)-1:0] stack_waddr,
	output logic [$clog2(MAX_POINTS)-1:0] stack_raddr
);

	import chgs_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_PIV_A, S_PIV_B,
		S_SRT_RD, S_SRT_CUR, S_SRT_CHK, S_SRT_SREF, S_SRT_CMP, S_SRT_DEC,
		S_SCN_RD, S_SCN_P, S_SCN_CHK, S_SCN_TST, S_SCN_SEC,
		S_EM_RD, S_EM_LD
	} state_t;

	state_t state_q;
	logic [NW-1:0] count_q, i_q, j_q, d_q, k_q;
	logic [NW-1:0] cnt_next, j_m1, d_m3, i_p1;
	logic drop_q, cnt_full, in_acc, out_acc, em_wait_q;

	assign cnt_full = (count_q == NW'(MAX_POINTS));
	assign cnt_next = cnt_full ? count_q : count_q + NW'(1);
	assign j_m1     = j_q - NW'(1);
	assign d_m3     = d_q - NW'(3);
	assign i_p1     = i_q + NW'(1);
	assign in_ready = (state_q == S_IDLE) && !em_wait_q;
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;

	assign store_waddr = count_q[IW-1:0];
	assign store_raddr = i_q[IW-1:0];
	assign sort_waddr  = j_q[IW-1:0];
	assign sort_raddr  = (state_q == S_SRT_CHK) ? j_m1[IW-1:0] : i_q[IW-1:0];
	assign stack_waddr = d_q[IW-1:0];
	assign stack_raddr = (state_q == S_SCN_TST) ? d_m3[IW-1:0] : k_q[IW-1:0];

	// Decode datapath commands from the state
	always_comb begin
		cmd = '0;
		cmd.turn_scan = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				cmd.store_we = in_acc && !cnt_full;
				cmd.out_zero = in_acc && last_point && (cnt_next < NW'(MIN_HULL));
			end
			S_PIV_B: begin
				cmd.piv_upd   = 1'b1;
				cmd.piv_first = (i_q == '0);
			end
			S_SRT_CUR:  cmd.cur_ld = 1'b1;
			S_SRT_CHK:  cmd.sort_we = (j_q == '0);
			S_SRT_SREF: cmd.sref_ld = 1'b1;
			S_SRT_CMP:  cmd.turn_scan = 1'b0;
			S_SRT_DEC: begin
				cmd.sort_we   = 1'b1;
				cmd.sort_wsel = stat.ahead;
			end
			S_SCN_P: cmd.p_ld = 1'b1;
			S_SCN_CHK: begin
				cmd.stack_we = (d_q <= NW'(1));
				cmd.push     = (d_q <= NW'(1));
			end
			S_SCN_TST: begin
				cmd.stack_we = stat.turn_pos;
				cmd.push     = stat.turn_pos;
				cmd.pop      = !stat.turn_pos;
			end
			S_SCN_SEC: cmd.sec_ld = 1'b1;
			S_EM_LD:   cmd.out_ld = 1'b1;
			default: ;
		endcase
	end

	// Hold state, counters and the result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			d_q         <= '0;
			k_q         <= '0;
			drop_q      <= 1'b0;
			em_wait_q   <= 1'b0;
			out_valid   <= 1'b0;
			last_vertex <= 1'b0;
			hull_empty  <= 1'b0;
			overflow    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (em_wait_q) begin
						// Result word on the output: wait for the receiver
						if (out_acc) begin
							out_valid <= 1'b0;
							em_wait_q <= 1'b0;
							if (last_vertex) begin
								count_q <= '0;
								drop_q  <= 1'b0;
								d_q     <= '0;
							end else begin
								k_q     <= k_q + NW'(1);
								state_q <= S_EM_RD;
							end
						end
					end else if (in_acc) begin
						count_q <= cnt_next;
						drop_q  <= drop_q | cnt_full;
						if (last_point) begin
							if (cnt_next < NW'(MIN_HULL)) begin
								out_valid   <= 1'b1;
								last_vertex <= 1'b1;
								hull_empty  <= 1'b1;
								overflow    <= drop_q | cnt_full;
								em_wait_q   <= 1'b1;
								d_q         <= '0;
							end else begin
								i_q     <= '0;
								state_q <= S_PIV_A;
							end
						end
					end
				end
				S_PIV_A: state_q <= S_PIV_B;
				S_PIV_B: begin
					if (i_p1 == count_q) begin
						i_q     <= '0;
						state_q <= S_SRT_RD;
					end else begin
						i_q     <= i_p1;
						state_q <= S_PIV_A;
					end
				end
				S_SRT_RD: state_q <= S_SRT_CUR;
				S_SRT_CUR: begin
					j_q     <= i_q;
					state_q <= S_SRT_CHK;
				end
				S_SRT_CHK: begin
					if (j_q == '0) begin
						if (i_p1 == count_q) begin
							i_q     <= '0;
							d_q     <= '0;
							state_q <= S_SCN_RD;
						end else begin
							i_q     <= i_p1;
							state_q <= S_SRT_RD;
						end
					end else begin
						state_q <= S_SRT_SREF;
					end
				end
				S_SRT_SREF: state_q <= S_SRT_CMP;
				S_SRT_CMP:  state_q <= S_SRT_DEC;
				S_SRT_DEC: begin
					if (stat.ahead) begin
						j_q     <= j_m1;
						state_q <= S_SRT_CHK;
					end else if (i_p1 == count_q) begin
						i_q     <= '0;
						d_q     <= '0;
						state_q <= S_SCN_RD;
					end else begin
						i_q     <= i_p1;
						state_q <= S_SRT_RD;
					end
				end
				S_SCN_RD: state_q <= S_SCN_P;
				S_SCN_P:  state_q <= S_SCN_CHK;
				S_SCN_CHK: begin
					if (d_q <= NW'(1)) begin
						d_q <= d_q + NW'(1);
						if (i_p1 == count_q) begin
							k_q     <= '0;
							state_q <= S_EM_RD;
						end else begin
							i_q     <= i_p1;
							state_q <= S_SCN_RD;
						end
					end else begin
						state_q <= S_SCN_TST;
					end
				end
				S_SCN_TST: begin
					if (stat.turn_pos) begin
						d_q <= d_q + NW'(1);
						if (i_p1 == count_q) begin
							k_q     <= '0;
							state_q <= S_EM_RD;
						end else begin
							i_q     <= i_p1;
							state_q <= S_SCN_RD;
						end
					end else begin
						// Drop the top; refetch the new second entry when there is one
						d_q     <= d_q - NW'(1);
						state_q <= (d_q >= NW'(3)) ? S_SCN_SEC : S_SCN_CHK;
					end
				end
				S_SCN_SEC: state_q <= S_SCN_CHK;
				S_EM_RD:   state_q <= S_EM_LD;
				S_EM_LD: begin
					out_valid   <= 1'b1;
					last_vertex <= (k_q + NW'(1) == d_q);
					hull_empty  <= 1'b0;
					overflow    <= drop_q;
					em_wait_q   <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/convex_hull_graham_scan.sv */
// Graham-scan convex hull of a set of 2-D integer points.
// Input channel (in_valid/in_ready): one point word per cycle; last_point marks the
// final word of a set. Points past MAX_POINTS are dropped and flag overflow.
// After the closing word, in_ready stays low while the block finds the pivot,
// insertion-sorts the points by angle around it (up to n*n/2 shifts) and runs the
// scan. These phases use three point memories and one shared cross-product unit.
// Output channel (out_valid/out_ready): hull vertices counterclockwise from the
// pivot, last_vertex on the final one; the next word is read only once the last
// is accepted. A set of fewer than 3 points gives one word with hull_empty set.
// A stalled receiver holds the word and the whole block; the next set is taken
// once the final word is accepted. Reset clears all control state; the point
// memories need no clearing.
module convex_hull_graham_scan #(
	parameter int MAX_POINTS = chgs_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = chgs_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [chgs_pkg::FIELD_W-1:0] point_x,
	input  logic signed [chgs_pkg::FIELD_W-1:0] point_y,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [chgs_pkg::FIELD_W-1:0] vertex_x,
	output logic signed [chgs_pkg::FIELD_W-1:0] vertex_y,
	output logic                                last_vertex,
	output logic                                hull_empty,
	output logic                                overflow
);

	import chgs_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [IW-1:0] store_waddr, store_raddr, sort_waddr, sort_raddr, stack_waddr, stack_raddr;

	chgs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready),
		.last_vertex(last_vertex), .hull_empty(hull_empty), .overflow(overflow),
		.cmd(cmd), .stat(stat),
		.store_waddr(store_waddr), .store_raddr(store_raddr),
		.sort_waddr(sort_waddr), .sort_raddr(sort_raddr),
		.stack_waddr(stack_waddr), .stack_raddr(stack_raddr)
	);

	chgs_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .stat(stat),
		.store_waddr(store_waddr), .store_raddr(store_raddr),
		.sort_waddr(sort_waddr), .sort_raddr(sort_raddr),
		.stack_waddr(stack_waddr), .stack_raddr(stack_raddr),
		.point_x(point_x), .point_y(point_y),
		.vertex_x(vertex_x), .vertex_y(vertex_y)
	);

endmodule

/* src/chgs_checker.sv */
module chgs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [15:0] point_x,
	input logic [15:0] point_y,
	input logic        last_point,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] vertex_x,
	input logic [15:0] vertex_y,
	input logic        last_vertex,
	input logic        hull_empty,
	input logic        overflow
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y)
		&& $stable(last_vertex))
		else $error("result word changed under stall");

	// Never take a point while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input open while a result is pending");

	// Empty hull is a single zero word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hull_empty |-> last_vertex && vertex_x == 16'd0 && vertex_y == 16'd0)
		else $error("empty hull word malformed");

	// After the final word the output goes quiet and the input reopens
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_vertex |=> !out_valid && in_ready)
		else $error("hull did not end cleanly");

endmodule

bind convex_hull_graham_scan chgs_checker u_chgs_checker (.*);
